FILE: sv/kfsl_pkg.sv
// Shared types, constants and handshake structs of the keyframe segment locator.
`timescale 1ns / 1ps

package kfsl_pkg;

    localparam int MAX_KEYS  = 16;
    localparam int FRAC_BITS = 16;

    localparam int KEY_W  = FRAC_BITS + 1;
    localparam int VAL_W  = FRAC_BITS;
    localparam int IDX_W  = $clog2(MAX_KEYS);
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int STEP_W = $clog2(FRAC_BITS + 1);
    localparam int MODE_W = 2;

    localparam logic [KEY_W-1:0] FIX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        RES_SINGLE_CUR,
        RES_SINGLE_PREV,
        RES_BLEND
    } t_res_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_DIV,
        S_OUT_CUR,
        S_OUT_PREV,
        S_OUT_BLEND
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     clr_all;
        logic     kill;
        logic     take_idx;
        logic     pos_clr;
        logic     pos_inc;
        logic     rd_en;
        logic     rd_from_j;
        logic     j_load;
        logic     j_dec;
        logic     wr_shift;
        logic     wr_insert;
        logic     wr_last;
        logic     div_start;
        logic     res_load;
        t_res_sel res_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  disabled;
        logic  key_bad;
        logic  full;
        logic  query_bad;
        logic  few_keys;
        logic  pos_at_end;
        logic  cur_less;
        logic  cur_equal;
        logic  pos_zero;
        logic  j_at_pos;
        logic  div_done;
        logic  out_free;
    } t_dp_sts;

endpackage

FILE: sv/kfsl_div.sv
// Restoring divider, one quotient bit per cycle, for the blend factor.
`timescale 1ns / 1ps

module kfsl_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [kfsl_pkg::KEY_W-1:0]       i_num,
    input  logic [kfsl_pkg::KEY_W-1:0]       i_den,
    output logic                             o_done,
    output logic [kfsl_pkg::FRAC_BITS-1:0]   o_quo
);

    logic                           r_busy;
    logic                           r_done;
    logic [kfsl_pkg::STEP_W-1:0]    r_cnt;
    logic [kfsl_pkg::KEY_W-1:0]     r_rem;
    logic [kfsl_pkg::KEY_W-1:0]     r_den;
    logic [kfsl_pkg::FRAC_BITS-1:0] r_quo;

    logic [kfsl_pkg::KEY_W:0]       shifted;
    logic [kfsl_pkg::KEY_W:0]       diff;
    logic                           ge;

    // Remainder stays below the divisor, so one compare-subtract per bit.
    assign shifted = {r_rem, 1'b0};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= kfsl_pkg::STEP_W'(kfsl_pkg::FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - kfsl_pkg::STEP_W'(1);
                if (r_cnt == kfsl_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[kfsl_pkg::KEY_W-1:0] : shifted[kfsl_pkg::KEY_W-1:0];
            r_quo <= {r_quo[kfsl_pkg::FRAC_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: sv/kfsl_datapath.sv
// Key table memory, counters, scan registers, divider and output register.
`timescale 1ns / 1ps

module kfsl_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kfsl_pkg::t_dp_cmd               i_cmd,
    output kfsl_pkg::t_dp_sts               o_sts,
    input  logic [kfsl_pkg::MODE_W-1:0]     i_mode,
    input  logic [kfsl_pkg::VAL_W-1:0]      i_key_value,
    input  logic                            i_key_is_one,
    input  logic                            i_key_invalid,
    input  logic [kfsl_pkg::KEY_W-1:0]      i_fraction,
    input  logic                            i_fraction_invalid,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_result_kind,
    output logic [kfsl_pkg::IDX_W-1:0]      o_first_index,
    output logic [kfsl_pkg::IDX_W-1:0]      o_second_index,
    output logic [kfsl_pkg::KEY_W-1:0]      o_blend_factor
);

    // Table storage, one write and one registered read per cycle.
    logic [kfsl_pkg::KEY_W-1:0] mem_key   [kfsl_pkg::MAX_KEYS];
    logic [kfsl_pkg::IDX_W-1:0] mem_first [kfsl_pkg::MAX_KEYS];
    logic [kfsl_pkg::IDX_W-1:0] mem_last  [kfsl_pkg::MAX_KEYS];

    logic [kfsl_pkg::KEY_W-1:0] r_rd_key;
    logic [kfsl_pkg::IDX_W-1:0] r_rd_first;
    logic [kfsl_pkg::IDX_W-1:0] r_rd_last;

    kfsl_pkg::t_mode            r_mode;
    logic [kfsl_pkg::KEY_W-1:0] r_val;
    logic                       r_key_bad;
    logic                       r_query_bad;
    logic [kfsl_pkg::IDX_W-1:0] r_idx;

    logic [kfsl_pkg::CNT_W-1:0] r_dist;
    logic [kfsl_pkg::CNT_W-1:0] r_app;
    logic                       r_disabled;

    logic [kfsl_pkg::CNT_W-1:0] r_pos;
    logic [kfsl_pkg::CNT_W-1:0] r_j;
    logic [kfsl_pkg::KEY_W-1:0] r_prev_key;
    logic [kfsl_pkg::IDX_W-1:0] r_prev_last;

    logic                       r_out_valid;
    logic                       r_out_kind;
    logic [kfsl_pkg::IDX_W-1:0] r_out_first;
    logic [kfsl_pkg::IDX_W-1:0] r_out_second;
    logic [kfsl_pkg::KEY_W-1:0] r_out_factor;

    logic [kfsl_pkg::KEY_W-1:0] in_key;
    logic [kfsl_pkg::CNT_W-1:0] j_m1;
    logic [kfsl_pkg::IDX_W-1:0] rd_addr;
    logic [kfsl_pkg::IDX_W-1:0] wr_addr;
    logic                       div_done;
    logic [kfsl_pkg::FRAC_BITS-1:0] div_quo;

    assign in_key  = i_key_is_one ? kfsl_pkg::FIX_ONE : {1'b0, i_key_value};
    assign j_m1    = r_j - kfsl_pkg::CNT_W'(1);
    assign rd_addr = i_cmd.rd_from_j ? j_m1[kfsl_pkg::IDX_W-1:0] : r_pos[kfsl_pkg::IDX_W-1:0];
    assign wr_addr = i_cmd.wr_shift ? r_j[kfsl_pkg::IDX_W-1:0] : r_pos[kfsl_pkg::IDX_W-1:0];

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode      <= kfsl_pkg::t_mode'(i_mode);
            r_val       <= (i_mode == kfsl_pkg::MODE_APPEND) ? in_key : i_fraction;
            r_key_bad   <= i_key_invalid || (in_key > kfsl_pkg::FIX_ONE);
            r_query_bad <= i_fraction_invalid || (i_fraction > kfsl_pkg::FIX_ONE);
        end
        if (i_cmd.take_idx) begin
            r_idx <= r_app[kfsl_pkg::IDX_W-1:0];
        end
    end

    // Table counts and the disable flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist     <= '0;
            r_app      <= '0;
            r_disabled <= 1'b0;
        end else if (i_cmd.clr_all || i_cmd.kill) begin
            r_dist     <= '0;
            r_app      <= '0;
            r_disabled <= i_cmd.kill;
        end else begin
            if (i_cmd.take_idx) begin
                r_app <= r_app + kfsl_pkg::CNT_W'(1);
            end
            if (i_cmd.wr_insert) begin
                r_dist <= r_dist + kfsl_pkg::CNT_W'(1);
            end
        end
    end

    // Scan position, shift index and the entry left behind
    always_ff @(posedge i_clk) begin
        if (i_cmd.pos_clr) begin
            r_pos <= '0;
        end else if (i_cmd.pos_inc) begin
            r_pos       <= r_pos + kfsl_pkg::CNT_W'(1);
            r_prev_key  <= r_rd_key;
            r_prev_last <= r_rd_last;
        end
        if (i_cmd.j_load) begin
            r_j <= r_dist;
        end else if (i_cmd.j_dec) begin
            r_j <= j_m1;
        end
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_shift) begin
            mem_key[wr_addr]   <= r_rd_key;
            mem_first[wr_addr] <= r_rd_first;
            mem_last[wr_addr]  <= r_rd_last;
        end else if (i_cmd.wr_insert) begin
            mem_key[wr_addr]   <= r_val;
            mem_first[wr_addr] <= r_idx;
            mem_last[wr_addr]  <= r_idx;
        end else if (i_cmd.wr_last) begin
            mem_last[wr_addr]  <= r_idx;
        end
        if (i_cmd.rd_en) begin
            r_rd_key   <= mem_key[rd_addr];
            r_rd_first <= mem_first[rd_addr];
            r_rd_last  <= mem_last[rd_addr];
        end
    end

    kfsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_val - r_prev_key),
        .i_den   (r_rd_key - r_prev_key),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                kfsl_pkg::RES_SINGLE_CUR: begin
                    r_out_kind   <= 1'b0;
                    r_out_first  <= r_rd_first;
                    r_out_second <= '0;
                    r_out_factor <= '0;
                end
                kfsl_pkg::RES_BLEND: begin
                    r_out_kind   <= 1'b1;
                    r_out_first  <= r_prev_last;
                    r_out_second <= r_rd_first;
                    r_out_factor <= {1'b0, div_quo};
                end
                default: begin
                    r_out_kind   <= 1'b0;
                    r_out_first  <= r_prev_last;
                    r_out_second <= '0;
                    r_out_factor <= '0;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_first_index  = r_out_first;
    assign o_second_index = r_out_second;
    assign o_blend_factor = r_out_factor;

    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.disabled   = r_disabled;
        o_sts.key_bad    = r_key_bad;
        o_sts.full       = r_app >= kfsl_pkg::CNT_W'(kfsl_pkg::MAX_KEYS);
        o_sts.query_bad  = r_query_bad;
        o_sts.few_keys   = r_dist < kfsl_pkg::CNT_W'(2);
        o_sts.pos_at_end = r_pos == r_dist;
        o_sts.cur_less   = r_rd_key < r_val;
        o_sts.cur_equal  = r_rd_key == r_val;
        o_sts.pos_zero   = r_pos == '0;
        o_sts.j_at_pos   = r_j == r_pos;
        o_sts.div_done   = div_done;
        o_sts.out_free   = !r_out_valid || i_ready;
    end

    a_dist_le_app: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist <= r_app)
        else $error("distinct count exceeds appended count");

    a_disabled_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disabled |-> (r_dist == '0 && r_app == '0))
        else $error("disabled table is not empty");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_insert |-> (r_dist < r_app))
        else $error("insert without a claimed key index");

endmodule

FILE: sv/kfsl_ctrl.sv
// Sequencer for clear, append with sorted insert, and query with blend.
`timescale 1ns / 1ps

module kfsl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  kfsl_pkg::t_dp_sts  i_sts,
    output kfsl_pkg::t_dp_cmd  o_cmd
);

    kfsl_pkg::t_state r_state;
    kfsl_pkg::t_state n_state;
    logic             is_append;

    assign is_append = i_sts.mode == kfsl_pkg::MODE_APPEND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kfsl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            kfsl_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = kfsl_pkg::S_DECODE;
                end
            end
            kfsl_pkg::S_DECODE: begin
                n_state = kfsl_pkg::S_IDLE;
                if (is_append) begin
                    if (!i_sts.disabled && !i_sts.key_bad && !i_sts.full) begin
                        n_state = kfsl_pkg::S_SCAN_RD;
                    end
                end else if (i_sts.mode == kfsl_pkg::MODE_QUERY) begin
                    if (!i_sts.query_bad && !i_sts.few_keys) begin
                        n_state = kfsl_pkg::S_SCAN_RD;
                    end
                end
            end
            kfsl_pkg::S_SCAN_RD: begin
                if (!i_sts.pos_at_end) begin
                    n_state = kfsl_pkg::S_SCAN_CMP;
                end else if (is_append) begin
                    n_state = kfsl_pkg::S_SHIFT_RD;
                end else begin
                    n_state = kfsl_pkg::S_OUT_PREV;
                end
            end
            kfsl_pkg::S_SCAN_CMP: begin
                if (i_sts.cur_less) begin
                    n_state = kfsl_pkg::S_SCAN_RD;
                end else if (is_append) begin
                    n_state = i_sts.cur_equal ? kfsl_pkg::S_IDLE : kfsl_pkg::S_SHIFT_RD;
                end else if (i_sts.pos_zero || i_sts.cur_equal) begin
                    n_state = kfsl_pkg::S_OUT_CUR;
                end else begin
                    n_state = kfsl_pkg::S_DIV;
                end
            end
            kfsl_pkg::S_SHIFT_RD: begin
                n_state = i_sts.j_at_pos ? kfsl_pkg::S_INSERT : kfsl_pkg::S_SHIFT_WR;
            end
            kfsl_pkg::S_SHIFT_WR: begin
                n_state = kfsl_pkg::S_SHIFT_RD;
            end
            kfsl_pkg::S_INSERT: begin
                n_state = kfsl_pkg::S_IDLE;
            end
            kfsl_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = kfsl_pkg::S_OUT_BLEND;
                end
            end
            kfsl_pkg::S_OUT_CUR, kfsl_pkg::S_OUT_PREV, kfsl_pkg::S_OUT_BLEND: begin
                if (i_sts.out_free) begin
                    n_state = kfsl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kfsl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            kfsl_pkg::S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.capture = i_valid;
            end
            kfsl_pkg::S_DECODE: begin
                o_cmd.pos_clr = 1'b1;
                if (i_sts.mode == kfsl_pkg::MODE_CLEAR) begin
                    o_cmd.clr_all = 1'b1;
                end else if (is_append && !i_sts.disabled) begin
                    o_cmd.kill     = i_sts.key_bad;
                    o_cmd.take_idx = !i_sts.key_bad && !i_sts.full;
                end
            end
            kfsl_pkg::S_SCAN_RD: begin
                o_cmd.rd_en  = !i_sts.pos_at_end;
                o_cmd.j_load = i_sts.pos_at_end;
            end
            kfsl_pkg::S_SCAN_CMP: begin
                o_cmd.pos_inc = i_sts.cur_less;
                if (!i_sts.cur_less) begin
                    if (is_append) begin
                        o_cmd.wr_last = i_sts.cur_equal;
                        o_cmd.j_load  = !i_sts.cur_equal;
                    end else begin
                        o_cmd.div_start = !i_sts.pos_zero && !i_sts.cur_equal;
                    end
                end
            end
            kfsl_pkg::S_SHIFT_RD: begin
                o_cmd.rd_en     = !i_sts.j_at_pos;
                o_cmd.rd_from_j = 1'b1;
            end
            kfsl_pkg::S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.j_dec    = 1'b1;
            end
            kfsl_pkg::S_INSERT: begin
                o_cmd.wr_insert = 1'b1;
            end
            kfsl_pkg::S_OUT_CUR: begin
                o_cmd.res_load = i_sts.out_free;
                o_cmd.res_sel  = kfsl_pkg::RES_SINGLE_CUR;
            end
            kfsl_pkg::S_OUT_PREV: begin
                o_cmd.res_load = i_sts.out_free;
                o_cmd.res_sel  = kfsl_pkg::RES_SINGLE_PREV;
            end
            kfsl_pkg::S_OUT_BLEND: begin
                o_cmd.res_load = i_sts.out_free;
                o_cmd.res_sel  = kfsl_pkg::RES_BLEND;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/keyframe_segment_locator_core.sv
// Top level of the keyframe segment locator: sequencer plus table datapath.
//
//   Channel   Valid     Ready     Payload
//   input     i_valid   o_ready   i_mode, i_key_value, i_key_is_one, i_key_invalid,
//                                 i_fraction, i_fraction_invalid
//   result    o_valid   i_ready   o_result_kind, o_first_index, o_second_index,
//                                 o_blend_factor
//
// One item at a time. A clear, an ignored append or a dropped query ends
// after the decode state. An append walks the sorted table with a read and
// a compare per entry (one memory read port) and then shifts each entry above
// its slot up by one with a read and a write. A query walks the table the same
// way and, for a blend, runs the 16-step restoring divider until its done flag
// is seen.
// Synchronous active-low reset empties the table and enables it; the key
// memory is not cleared, since only entries below the distinct count are read.
// A result waits in the output register; a stalled result holds only a query
// that is ready to deliver, and o_ready rises again once it is taken.
`timescale 1ns / 1ps

module keyframe_segment_locator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [kfsl_pkg::MODE_W-1:0]         i_mode,
    input  logic [kfsl_pkg::VAL_W-1:0]          i_key_value,
    input  logic                                i_key_is_one,
    input  logic                                i_key_invalid,
    input  logic [kfsl_pkg::KEY_W-1:0]          i_fraction,
    input  logic                                i_fraction_invalid,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_result_kind,
    output logic [kfsl_pkg::IDX_W-1:0]          o_first_index,
    output logic [kfsl_pkg::IDX_W-1:0]          o_second_index,
    output logic [kfsl_pkg::KEY_W-1:0]          o_blend_factor
);

    // Command and status between sequencer and datapath
    kfsl_pkg::t_dp_cmd cmd;
    kfsl_pkg::t_dp_sts sts;

    kfsl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Table memory, scan registers, divider and the output register
    kfsl_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_mode             (i_mode),
        .i_key_value        (i_key_value),
        .i_key_is_one       (i_key_is_one),
        .i_key_invalid      (i_key_invalid),
        .i_fraction         (i_fraction),
        .i_fraction_invalid (i_fraction_invalid),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_result_kind      (o_result_kind),
        .o_first_index      (o_first_index),
        .o_second_index     (o_second_index),
        .o_blend_factor     (o_blend_factor)
    );

endmodule
